// ===== hdl/lss_pkg.sv =====
// ---------------------------------------------------------------------------
// lss_pkg: shared types and constants for the LIFO stack with search
// Request codes, status codes, the queued request record and width helpers.
// ---------------------------------------------------------------------------
package lss_pkg;

  // Stack geometry
  localparam int DEPTH   = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 4;
  localparam int FILL_W  = 5;

  // Request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // One queued request
  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
  } req_t;

  // Entry pointer to the 4-bit index field (wraps for large stacks)
  function automatic logic [IDX_W-1:0] to_index(input logic [PTR_W-1:0] ptr);
    logic [IDX_W+PTR_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, ptr};
    return wide[IDX_W-1:0];
  endfunction

  // Entry count to the 5-bit fill field (wraps for large stacks)
  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] cnt);
    logic [FILL_W+CNT_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, cnt};
    return wide[FILL_W-1:0];
  endfunction

endpackage

// ===== hdl/lss_front.sv =====
// ---------------------------------------------------------------------------
// lss_front: request intake and queue
// Takes requests from the input channel, decodes the command and holds them
// in a short FIFO until the back end is ready for them.
// ---------------------------------------------------------------------------
module lss_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lss_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [lss_pkg::DATA_W-1:0] in_value,
  output logic                         q_valid,
  output lss_pkg::req_t                q_req,
  input  logic                         q_pop
);

  lss_pkg::req_t               fifo_r [lss_pkg::QDEPTH];
  logic [lss_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lss_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lss_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        push;
  lss_pkg::req_t               req_in;

  // Decode the incoming request
  always_comb begin
    req_in.cmd   = lss_pkg::cmd_t'(in_cmd);
    req_in.value = in_value;
  end

  assign in_stall = (cnt_r == lss_pkg::QCNT_W'(lss_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = fifo_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

// ===== hdl/lss_back.sv =====
// ---------------------------------------------------------------------------
// lss_back: stack execution
// Holds the entries and the fill count, executes push, pop and clear on
// accept and scans for a find from the top entry down, one entry a cycle.
// ---------------------------------------------------------------------------
module lss_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lss_pkg::req_t                 q_req,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lss_pkg::STAT_W-1:0]    out_status,
  output logic [lss_pkg::IDX_W-1:0]     out_found_index,
  output logic [lss_pkg::FILL_W-1:0]    out_fill_level
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lss_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [lss_pkg::PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [lss_pkg::DATA_W-1:0]  key_r, key_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lss_pkg::status_t            status_r, status_nxt;
  logic [lss_pkg::IDX_W-1:0]   index_r, index_nxt;
  logic [lss_pkg::FILL_W-1:0]  fill_r, fill_nxt;

  logic [lss_pkg::DATA_W-1:0]  mem [lss_pkg::DEPTH];
  logic [lss_pkg::DATA_W-1:0]  rd_data_r;
  logic                        slot_free;
  logic                        is_full;
  logic                        is_empty;
  logic                        hit;
  logic                        last;
  logic                        wr_en;

  assign slot_free = !out_valid_r || !out_stall;
  assign is_full   = (count_r == lss_pkg::CNT_W'(lss_pkg::DEPTH));
  assign is_empty  = (count_r == '0);
  assign hit       = (rd_data_r == key_r);
  assign last      = (ptr_r == '0);
  assign q_pop     = (state_r == S_IDLE) && q_valid && slot_free;
  assign wr_en     = q_pop && (q_req.cmd == lss_pkg::CMD_PUSH) && !is_full;

  // Request execution and scan control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    index_nxt     = index_r;
    fill_nxt      = fill_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          out_valid_nxt = 1'b1;
          status_nxt    = lss_pkg::ST_OK;
          index_nxt     = '0;
          case (q_req.cmd)
            lss_pkg::CMD_PUSH: begin
              if (is_full) begin
                status_nxt = lss_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            lss_pkg::CMD_POP: begin
              if (is_empty) begin
                status_nxt = lss_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            lss_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            lss_pkg::CMD_FIND: begin
              if (is_empty) begin
                status_nxt = lss_pkg::ST_EMPTY;
              end else begin
                // result comes at the end of the scan
                out_valid_nxt = 1'b0;
                key_nxt       = q_req.value;
                ptr_nxt       = lss_pkg::PTR_W'(count_r - 1'b1);
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              status_nxt = lss_pkg::ST_OK;
            end
          endcase
          fill_nxt = lss_pkg::to_fill(count_nxt);
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          // finish only once the output slot can take the result
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = hit ? lss_pkg::ST_OK : lss_pkg::ST_MISSING;
            index_nxt     = hit ? lss_pkg::to_index(ptr_r) : '0;
            fill_nxt      = lss_pkg::to_fill(count_r);
            state_nxt     = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r    <= ptr_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
    fill_r   <= fill_nxt;
  end

  // Entry storage, written on an accepted push; read data follows the scan
  // pointer so it lines up with ptr_r in the next cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[lss_pkg::PTR_W-1:0]] <= q_req.value;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = index_r;
  assign out_fill_level  = fill_r;

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
// Push, pop and clear: executed on accept in the execution unit, one request a cycle sustained while out_stall is low.
// Find: scans entries from the top down, up to the fill level (16 at most).
// Result is offered in the cycle after accept for push/pop/clear, and at the end of the scan for find.
// A two-entry request queue lets intake continue while a find scans.
// Reset (synchronous, rst_n low) empties the stack and the queue; entries are not cleared.
// ---------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack with top-down search
// Front end queues requests; back end holds the stack and answers each
// request with status, found index and fill level.
// ---------------------------------------------------------------------------
module lifo_stack_with_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lss_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [lss_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lss_pkg::STAT_W-1:0]        out_status,
  output logic [lss_pkg::IDX_W-1:0]         out_found_index,
  output logic [lss_pkg::FILL_W-1:0]        out_fill_level
);

  logic          q_valid;
  logic          q_pop;
  lss_pkg::req_t q_req;

  // Request intake
  lss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  // Stack execution
  lss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_fill_level  (out_fill_level)
  );

endmodule
